[rtl/core/ccs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccs_pkg: shared types and constants of the child order clip sizer
// Field widths, status codes, register indexes and the records that travel
// between the front stages, the divider cells and the back stages.
// ----------------------------------------------------------------------------
package ccs_pkg;

    localparam int QTY_W     = 32;
    localparam int TIME_W    = 48;
    localparam int RATE_FRAC = 16;
    localparam int RATE_W    = RATE_FRAC + 1;
    localparam int GUARD_W   = 32;
    localparam int STATUS_W  = 3;

    // auction guard bands take part in the gate
    localparam logic HOURS_CHECK = 1'b1;

    // configuration port
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = TIME_W;

    localparam logic [CFG_IDX_W-1:0] CFG_RATE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOT      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_CLIP = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_BEG  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_END  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_OPEN_GRD = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_GRD = 3'd7;

    // status codes
    localparam logic [STATUS_W-1:0] ST_SIZED    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_EXEC = 3'd1;
    localparam logic [STATUS_W-1:0] ST_GUARD    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_WINDOW   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NONE     = 3'd4;

    // stream widths
    localparam int IN_W      = 3 * TIME_W + 3 + 4 * QTY_W;
    localparam int IN_DATA_W = ((IN_W + 7) / 8) * 8;
    localparam int OUT_W     = QTY_W + STATUS_W + 2;
    localparam int OUT_DATA_W = ((OUT_W + 7) / 8) * 8;

    // one divider cell per quotient bit
    localparam int DIV_CELLS = QTY_W;

    typedef struct packed {
        logic [RATE_W-1:0]  rate;
        logic [QTY_W-1:0]   display_cap;
        logic [QTY_W-1:0]   lot_qty;
        logic [QTY_W-1:0]   min_clip;
        logic [TIME_W-1:0]  window_start;
        logic [TIME_W-1:0]  window_stop;
        logic [GUARD_W-1:0] open_guard;
        logic [GUARD_W-1:0] close_guard;
    } cfg_t;

    typedef struct packed {
        logic [TIME_W-1:0] now_time;
        logic              market_ok;
        logic [TIME_W-1:0] open_time;
        logic              open_known;
        logic [TIME_W-1:0] close_time;
        logic              close_known;
        logic [QTY_W-1:0]  mkt_volume;
        logic [QTY_W-1:0]  due_qty;
        logic [QTY_W-1:0]  filled_qty;
        logic [QTY_W-1:0]  remaining_qty;
    } tick_t;

    // per-request side data carried alongside the lot divider
    typedef struct packed {
        logic [STATUS_W-1:0] gate;
        logic [QTY_W-1:0]    want;
        logic [QTY_W-1:0]    rem_qty;
        logic                pcap;
        logic                any;
    } side_t;

    typedef struct packed {
        side_t            side;
        logic [QTY_W-1:0] part;
        logic [QTY_W-1:0] dvd;
    } div_t;

endpackage

[rtl/core/ccs_div_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccs_div_cell: one restoring division step of the lot remainder
// Shifts in the next dividend bit, subtracts the lot when it fits and hands
// the request to the next cell.
// ----------------------------------------------------------------------------
module ccs_div_cell (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_valid,
    input  ccs_pkg::div_t           in_data,
    output logic                    in_ready,
    input  logic [ccs_pkg::QTY_W-1:0] lot,
    output logic                    out_valid,
    output ccs_pkg::div_t           out_data,
    input  logic                    out_ready
);

    logic                      valid_reg;
    ccs_pkg::div_t             data_reg;
    ccs_pkg::div_t             data_next;
    logic [ccs_pkg::QTY_W:0]   trial;
    logic [ccs_pkg::QTY_W:0]   diff;

    assign trial = {in_data.part, in_data.dvd[ccs_pkg::QTY_W-1]};
    assign diff  = trial - {1'b0, lot};

    always_comb begin
        data_next = in_data;
        if (trial >= {1'b0, lot}) begin
            data_next.part = diff[ccs_pkg::QTY_W-1:0];
        end else begin
            data_next.part = trial[ccs_pkg::QTY_W-1:0];
        end
        data_next.dvd = {in_data.dvd[ccs_pkg::QTY_W-2:0], 1'b0};
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

[rtl/core/ccs_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccs_front: release gate and clip caps
// Five stages: capture, gate and shortfall and product, remaining cap,
// participation cap, display cap. Emits the divider seed.
// ----------------------------------------------------------------------------
module ccs_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  ccs_pkg::cfg_t cfg,
    input  logic          in_valid,
    input  ccs_pkg::tick_t in_data,
    output logic          in_ready,
    output logic          out_valid,
    output ccs_pkg::div_t out_data,
    input  logic          out_ready
);

    localparam int PROD_W = ccs_pkg::QTY_W + ccs_pkg::RATE_W;
    localparam int CAP_W  = PROD_W - ccs_pkg::RATE_FRAC;

    typedef struct packed {
        logic [ccs_pkg::STATUS_W-1:0] gate;
        logic [ccs_pkg::QTY_W-1:0]    shortfall;
        logic [PROD_W-1:0]            prod;
        logic                         vol_nz;
        logic [ccs_pkg::QTY_W-1:0]    rem_qty;
    } st2_t;

    typedef struct packed {
        logic [ccs_pkg::STATUS_W-1:0] gate;
        logic [ccs_pkg::QTY_W-1:0]    want;
        logic [CAP_W-1:0]             cap;
        logic                         vol_nz;
        logic [ccs_pkg::QTY_W-1:0]    rem_qty;
    } st3_t;

    logic           v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic           r1, r2, r3, r4, r5;
    ccs_pkg::tick_t s1_reg;
    st2_t           s2_reg, s2_next;
    st3_t           s3_reg, s3_next;
    ccs_pkg::side_t s4_reg, s4_next;
    ccs_pkg::div_t  s5_reg, s5_next;

    logic [ccs_pkg::TIME_W:0] open_end;
    logic [ccs_pkg::TIME_W:0] now_plus;
    logic [ccs_pkg::QTY_W:0]  short_diff;
    logic                     open_blk, close_blk, win_out;
    logic                     capped;

    // ripple ready so bubbles collapse
    assign r5 = !v5_reg || out_ready;
    assign r4 = !v4_reg || r5;
    assign r3 = !v3_reg || r4;
    assign r2 = !v2_reg || r3;
    assign r1 = !v1_reg || r2;
    assign in_ready = r1;

    // stage 2: gate, shortfall, participation product
    assign open_end = {1'b0, s1_reg.open_time}
                    + {{(ccs_pkg::TIME_W + 1 - ccs_pkg::GUARD_W){1'b0}}, cfg.open_guard};
    assign now_plus = {1'b0, s1_reg.now_time}
                    + {{(ccs_pkg::TIME_W + 1 - ccs_pkg::GUARD_W){1'b0}}, cfg.close_guard};
    assign short_diff = {1'b0, s1_reg.due_qty} - {1'b0, s1_reg.filled_qty};

    always_comb begin
        open_blk  = s1_reg.open_known && ({1'b0, s1_reg.now_time} < open_end);
        close_blk = s1_reg.close_known && (now_plus >= {1'b0, s1_reg.close_time});
        win_out   = (s1_reg.now_time < cfg.window_start)
                 || (s1_reg.now_time >= cfg.window_stop);
        if (!s1_reg.market_ok) begin
            s2_next.gate = ccs_pkg::ST_NOT_EXEC;
        end else if (ccs_pkg::HOURS_CHECK && (open_blk || close_blk)) begin
            s2_next.gate = ccs_pkg::ST_GUARD;
        end else if (win_out) begin
            s2_next.gate = ccs_pkg::ST_WINDOW;
        end else begin
            s2_next.gate = ccs_pkg::ST_SIZED;
        end
        s2_next.shortfall = short_diff[ccs_pkg::QTY_W] ? '0
                                                         : short_diff[ccs_pkg::QTY_W-1:0];
        s2_next.prod    = {{ccs_pkg::RATE_W{1'b0}}, s1_reg.mkt_volume}
                        * {{ccs_pkg::QTY_W{1'b0}}, cfg.rate};
        s2_next.vol_nz  = s1_reg.mkt_volume != '0;
        s2_next.rem_qty = s1_reg.remaining_qty;
    end

    // stage 3: cap by remaining
    always_comb begin
        s3_next.gate    = s2_reg.gate;
        s3_next.want    = (s2_reg.shortfall < s2_reg.rem_qty) ? s2_reg.shortfall
                                                               : s2_reg.rem_qty;
        s3_next.cap     = s2_reg.prod[PROD_W-1:ccs_pkg::RATE_FRAC];
        s3_next.vol_nz  = s2_reg.vol_nz;
        s3_next.rem_qty = s2_reg.rem_qty;
    end

    // stage 4: participation cap
    assign capped = s3_reg.vol_nz
                 && (s3_reg.cap < {{(CAP_W - ccs_pkg::QTY_W){1'b0}}, s3_reg.want});

    always_comb begin
        s4_next.gate    = s3_reg.gate;
        s4_next.want    = capped ? s3_reg.cap[ccs_pkg::QTY_W-1:0] : s3_reg.want;
        s4_next.rem_qty = s3_reg.rem_qty;
        s4_next.pcap    = capped;
        s4_next.any     = s3_reg.want != '0;
    end

    // stage 5: display cap, seed the divider
    always_comb begin
        s5_next.side = s4_reg;
        if ((cfg.display_cap != '0) && (cfg.display_cap < s4_reg.want)) begin
            s5_next.side.want = cfg.display_cap;
        end
        s5_next.part = '0;
        s5_next.dvd  = s5_next.side.want;
    end

    assign out_valid = v5_reg;
    assign out_data  = s5_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            if (r1) begin
                v1_reg <= in_valid;
            end
            if (r2) begin
                v2_reg <= v1_reg;
            end
            if (r3) begin
                v3_reg <= v2_reg;
            end
            if (r4) begin
                v4_reg <= v3_reg;
            end
            if (r5) begin
                v5_reg <= v4_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (r1 && in_valid) begin
            s1_reg <= in_data;
        end
        if (r2 && v1_reg) begin
            s2_reg <= s2_next;
        end
        if (r3 && v2_reg) begin
            s3_reg <= s3_next;
        end
        if (r4 && v3_reg) begin
            s4_reg <= s4_next;
        end
        if (r5 && v4_reg) begin
            s5_reg <= s5_next;
        end
    end

endmodule

[rtl/core/ccs_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccs_back: lot truncation, minimum clip rule and result register
// Takes the remainder from the divider row, then applies the minimum clip
// and final residue rules.
// ----------------------------------------------------------------------------
module ccs_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  ccs_pkg::cfg_t cfg,
    input  logic          in_valid,
    input  ccs_pkg::div_t in_data,
    output logic          in_ready,
    output logic          out_valid,
    output logic [ccs_pkg::QTY_W-1:0]    out_clip,
    output logic [ccs_pkg::STATUS_W-1:0] out_status,
    output logic          out_pcap,
    output logic          out_held,
    input  logic          out_ready
);

    logic                         va_reg, vb_reg;
    logic                         ra, rb;
    ccs_pkg::side_t               a_reg, a_next;
    logic [ccs_pkg::QTY_W-1:0]    clip_reg, clip_next;
    logic [ccs_pkg::STATUS_W-1:0] status_reg, status_next;
    logic                         pcap_reg, pcap_next;
    logic                         held_reg, held_next;

    assign rb = !vb_reg || out_ready;
    assign ra = !va_reg || rb;
    assign in_ready = ra;

    // whole lots: want minus its remainder
    always_comb begin
        a_next = in_data.side;
        if (cfg.lot_qty != '0) begin
            a_next.want = in_data.side.want - in_data.part;
        end
    end

    always_comb begin
        clip_next   = '0;
        status_next = a_reg.gate;
        pcap_next   = 1'b0;
        held_next   = 1'b0;
        if (a_reg.gate == ccs_pkg::ST_SIZED) begin
            status_next = ccs_pkg::ST_NONE;
            if (a_reg.any) begin
                pcap_next = a_reg.pcap;
                clip_next = a_reg.want;
                if (a_reg.want < cfg.min_clip) begin
                    if (a_reg.rem_qty <= cfg.min_clip) begin
                        clip_next = a_reg.rem_qty;
                    end else begin
                        clip_next = '0;
                        held_next = 1'b1;
                    end
                end
                if (clip_next != '0) begin
                    status_next = ccs_pkg::ST_SIZED;
                end
            end
        end
    end

    assign out_valid  = vb_reg;
    assign out_clip   = clip_reg;
    assign out_status = status_reg;
    assign out_pcap   = pcap_reg;
    assign out_held   = held_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end else begin
            if (ra) begin
                va_reg <= in_valid;
            end
            if (rb) begin
                vb_reg <= va_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ra && in_valid) begin
            a_reg <= a_next;
        end
        if (rb && va_reg) begin
            clip_reg   <= clip_next;
            status_reg <= status_next;
            pcap_reg   <= pcap_next;
            held_reg   <= held_next;
        end
    end

endmodule

[rtl/core/child_order_clip_sizer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// child_order_clip_sizer: per-tick child order release gate and clip sizing
// Gates release on executability, auction guard bands and the execution
// window, then caps the schedule shortfall by remaining, participation,
// display size and whole lots, and applies the minimum clip rule.
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+-------------------------------------
//  s_       | in  | s_tvalid/s_tready  | one market tick request (s_tdata)
//  m_       | out | m_tvalid/m_tready  | one clip decision per tick (m_tdata)
//  cfg_     | in  | cfg_wr_en          | register write, index and data
//
//  One request accepted per cycle unless m_tready stalls the pipe; a tick
//  passes 5 front stages, 32 divider cells (one remainder bit each, for the
//  lot truncation), the lot subtract stage and the result register.
//  Reset (aresetn low, synchronous) empties the pipe and loads register
//  defaults. A stall on m_tready backs up only as far as the pipe is full;
//  empty stages keep taking requests.
//
module child_order_clip_sizer (
    input  logic                              aclk,
    input  logic                              aresetn,
    // market tick: now_time, market_ok, open_time, open_known, close_time,
    // close_known, mkt_volume, due_qty, filled_qty, remaining_qty
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [ccs_pkg::IN_DATA_W-1:0]     s_tdata,
    // result: clip_qty, status, participation_capped, min_clip_held
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [ccs_pkg::OUT_DATA_W-1:0]    m_tdata,
    // configuration writes
    input  logic                              cfg_wr_en,
    input  logic [ccs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ccs_pkg::CFG_W-1:0]         cfg_wdata
);

    localparam int N = ccs_pkg::DIV_CELLS;

    ccs_pkg::cfg_t  cfg_reg;
    ccs_pkg::tick_t tick;

    logic          chain_valid [0:N];
    logic          chain_ready [0:N];
    ccs_pkg::div_t chain_data  [0:N];

    logic [ccs_pkg::QTY_W-1:0]    out_clip;
    logic [ccs_pkg::STATUS_W-1:0] out_status;
    logic                         out_pcap;
    logic                         out_held;

    // ---------------- configuration registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.rate         <= {1'b1, {ccs_pkg::RATE_FRAC{1'b0}}};
            cfg_reg.display_cap  <= '0;
            cfg_reg.lot_qty      <= '0;
            cfg_reg.min_clip     <= '0;
            cfg_reg.window_start <= '0;
            cfg_reg.window_stop  <= '1;
            cfg_reg.open_guard   <= '0;
            cfg_reg.close_guard  <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                ccs_pkg::CFG_RATE: begin
                    cfg_reg.rate <= cfg_wdata[ccs_pkg::RATE_W-1:0];
                end
                ccs_pkg::CFG_DISPLAY: begin
                    cfg_reg.display_cap <= cfg_wdata[ccs_pkg::QTY_W-1:0];
                end
                ccs_pkg::CFG_LOT: begin
                    cfg_reg.lot_qty <= cfg_wdata[ccs_pkg::QTY_W-1:0];
                end
                ccs_pkg::CFG_MIN_CLIP: begin
                    cfg_reg.min_clip <= cfg_wdata[ccs_pkg::QTY_W-1:0];
                end
                ccs_pkg::CFG_WIN_BEG: begin
                    cfg_reg.window_start <= cfg_wdata[ccs_pkg::TIME_W-1:0];
                end
                ccs_pkg::CFG_WIN_END: begin
                    cfg_reg.window_stop <= cfg_wdata[ccs_pkg::TIME_W-1:0];
                end
                ccs_pkg::CFG_OPEN_GRD: begin
                    cfg_reg.open_guard <= cfg_wdata[ccs_pkg::GUARD_W-1:0];
                end
                ccs_pkg::CFG_CLOSE_GRD: begin
                    cfg_reg.close_guard <= cfg_wdata[ccs_pkg::GUARD_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // ---------------- unpack the tick (lowest field first) ----------------
    assign tick.now_time        = s_tdata[47:0];
    assign tick.market_ok       = s_tdata[48];
    assign tick.open_time       = s_tdata[96:49];
    assign tick.open_known      = s_tdata[97];
    assign tick.close_time      = s_tdata[145:98];
    assign tick.close_known     = s_tdata[146];
    assign tick.mkt_volume      = s_tdata[178:147];
    assign tick.due_qty         = s_tdata[210:179];
    assign tick.filled_qty      = s_tdata[242:211];
    assign tick.remaining_qty   = s_tdata[274:243];

    // ---------------- gate and caps ----------------
    ccs_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_data   (tick),
        .in_ready  (s_tready),
        .out_valid (chain_valid[0]),
        .out_data  (chain_data[0]),
        .out_ready (chain_ready[0])
    );

    // ---------------- lot remainder: row of divider cells ----------------
    for (genvar k = 0; k < N; k++) begin : g_cell
        ccs_div_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (chain_valid[k]),
            .in_data   (chain_data[k]),
            .in_ready  (chain_ready[k]),
            .lot       (cfg_reg.lot_qty),
            .out_valid (chain_valid[k+1]),
            .out_data  (chain_data[k+1]),
            .out_ready (chain_ready[k+1])
        );
    end

    // ---------------- truncation, minimum clip, result ----------------
    ccs_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .in_valid   (chain_valid[N]),
        .in_data    (chain_data[N]),
        .in_ready   (chain_ready[N]),
        .out_valid  (m_tvalid),
        .out_clip   (out_clip),
        .out_status (out_status),
        .out_pcap   (out_pcap),
        .out_held   (out_held),
        .out_ready  (m_tready)
    );

    assign m_tdata = {{(ccs_pkg::OUT_DATA_W - ccs_pkg::OUT_W){1'b0}},
                      out_held, out_pcap, out_status, out_clip};

    // ---------------- checks ----------------
    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (out_status <= ccs_pkg::ST_NONE))
        else $error("status code out of range");

    a_sized_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((out_status == ccs_pkg::ST_SIZED) == (out_clip != '0)))
        else $error("clip quantity disagrees with status");

    a_gated_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (out_status == ccs_pkg::ST_NOT_EXEC
                      || out_status == ccs_pkg::ST_GUARD
                      || out_status == ccs_pkg::ST_WINDOW))
        |-> (!out_pcap && !out_held))
        else $error("flags set on a gated tick");

    a_held_none: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_held) |-> (out_status == ccs_pkg::ST_NONE))
        else $error("held clip without nothing-to-send status");

endmodule
